@@ sv/trc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package trc_pkg;

   localparam int MEM_WORDS = 256;
   localparam int REG_COUNT = 8;

   localparam int DATA_W = 32;
   localparam int ADDR_W = 8;
   localparam int PC_W   = 8;
   localparam int MEM_AW = $clog2(MEM_WORDS);
   localparam int REG_AW = $clog2(REG_COUNT);

   localparam logic [1:0] ACT_MEM_WR = 2'd0;
   localparam logic [1:0] ACT_MEM_RD = 2'd1;
   localparam logic [1:0] ACT_STEP   = 2'd2;
   localparam logic [1:0] ACT_REG_RD = 2'd3;

   localparam logic [7:0] OP_LOAD  = 8'h01;
   localparam logic [7:0] OP_STORE = 8'h02;
   localparam logic [7:0] OP_ADD   = 8'h03;
   localparam logic [7:0] OP_SUB   = 8'h04;
   localparam logic [7:0] OP_MUL   = 8'h05;
   localparam logic [7:0] OP_MOV   = 8'h06;
   localparam logic [7:0] OP_JNZ   = 8'h07;
   localparam logic [7:0] OP_DEC   = 8'h08;
   localparam logic [7:0] OP_HALT  = 8'hFF;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_UNKNOWN = 2'd1;
   localparam logic [1:0] ST_BADREG  = 2'd2;
   localparam logic [1:0] ST_HALTED  = 2'd3;

   typedef struct packed {
      logic clear;
      logic load_req;
      logic issue;
      logic take_read;
      logic take_instr;
      logic decode;
      logic oper;
      logic oper2;
      logic load_rsp;
   } trc_cmd_type;

   typedef struct packed {
      logic       clear_last;
      logic [1:0] action;
      logic       halted;
      logic       addr_bad;
      logic       short_op;
      logic       alu_op;
   } trc_sts_type;

   // byte address folded onto the memory depth (constant table)
   function automatic logic [MEM_AW-1:0] mem_index(input logic [ADDR_W-1:0] a);
      logic [MEM_AW-1:0] r;
      r = '0;
      for (int i = 0; i < (1 << ADDR_W); i++) begin
         if (a == ADDR_W'(i)) r = MEM_AW'(i % MEM_WORDS);
      end
      return r;
   endfunction

   function automatic logic reg_ok(input logic [ADDR_W-1:0] r);
      return r < ADDR_W'(REG_COUNT);
   endfunction

   function automatic logic [REG_AW-1:0] reg_idx(input logic [ADDR_W-1:0] r);
      return r[REG_AW-1:0];
   endfunction

endpackage

`default_nettype wire

@@ sv/tiny_register_cpu_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// channel | direction | ports
// --------+-----------+---------------------------------------------------------
// req     | in        | req_valid, req_ready, req_action, req_address, req_write_data
// rsp     | out       | rsp_valid, rsp_ready, rsp_read_data, rsp_program_counter,
//         |           | rsp_halted, rsp_status
//
// One word at a time. Paths: memory write, halted step, bad register read ISSUE,
// DONE; memory/register read ISSUE, READ, DONE; step ISSUE, FETCH, DECODE, DONE (MOV,
// HALT, skipped, bad index), OPER, DONE (LOAD, STORE, JNZ, DEC) or OPER, OPER2, DONE
// (ADD, SUB, MUL); a new word is taken the cycle after the result is loaded. Single
// memory and register file read ports, used once per operand, set these paths. Reset
// clears pc, sets the run flag, then a pass zeroes memory and registers with req_ready
// low. A result held by rsp_ready low does not block the next req word.

module tiny_register_cpu_core import trc_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic [1:0]               req_action,
   input  wire logic [ADDR_W-1:0]        req_address,
   input  wire logic signed [DATA_W-1:0] req_write_data,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic signed [DATA_W-1:0]      rsp_read_data,
   output logic [PC_W-1:0]               rsp_program_counter,
   output logic                          rsp_halted,
   output logic [1:0]                    rsp_status
);

   trc_cmd_type cmd;
   trc_sts_type sts;

   trc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   trc_dpath u_dpath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .req_action          (req_action),
      .req_address         (req_address),
      .req_write_data      (req_write_data),
      .rsp_read_data       (rsp_read_data),
      .rsp_program_counter (rsp_program_counter),
      .rsp_halted          (rsp_halted),
      .rsp_status          (rsp_status)
   );

endmodule

`default_nettype wire

@@ sv/trc_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module trc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] ram_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) ram_ff[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= ram_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ sv/trc_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module trc_ctrl import trc_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   input  wire trc_sts_type sts,
   output trc_cmd_type      cmd
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_ISSUE  = 4'd1;
   localparam logic [3:0] S_READ   = 4'd2;
   localparam logic [3:0] S_FETCH  = 4'd3;
   localparam logic [3:0] S_DECODE = 4'd4;
   localparam logic [3:0] S_OPER   = 4'd5;
   localparam logic [3:0] S_OPER2  = 4'd6;
   localparam logic [3:0] S_DONE   = 4'd7;
   localparam logic [3:0] S_CLEAR  = 4'd8;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            // zero one memory word per cycle after reset
            cmd.clear = 1'b1;
            if (sts.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_ISSUE;
            end
         end
         S_ISSUE: begin
            cmd.issue = 1'b1;
            unique case (sts.action)
               ACT_MEM_WR: state_in = S_DONE;
               ACT_MEM_RD: state_in = S_READ;
               ACT_STEP:   state_in = sts.halted ? S_DONE : S_FETCH;
               ACT_REG_RD: state_in = sts.addr_bad ? S_DONE : S_READ;
               default:    state_in = S_DONE;
            endcase
         end
         S_READ: begin
            cmd.take_read = 1'b1;
            state_in      = S_DONE;
         end
         S_FETCH: begin
            cmd.take_instr = 1'b1;
            state_in       = S_DECODE;
         end
         S_DECODE: begin
            cmd.decode = 1'b1;
            state_in   = sts.short_op ? S_DONE : S_OPER;
         end
         S_OPER: begin
            cmd.oper = 1'b1;
            state_in = sts.alu_op ? S_OPER2 : S_DONE;
         end
         S_OPER2: begin
            cmd.oper2 = 1'b1;
            state_in  = S_DONE;
         end
         S_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid_in = cmd.load_rsp | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

@@ sv/trc_dpath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module trc_dpath import trc_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire trc_cmd_type              cmd,
   output trc_sts_type                   sts,
   input  wire logic [1:0]               req_action,
   input  wire logic [ADDR_W-1:0]        req_address,
   input  wire logic signed [DATA_W-1:0] req_write_data,
   output logic signed [DATA_W-1:0]      rsp_read_data,
   output logic [PC_W-1:0]               rsp_program_counter,
   output logic                          rsp_halted,
   output logic [1:0]                    rsp_status
);

   logic [1:0]        action_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [DATA_W-1:0] wdata_ff;
   logic [DATA_W-1:0] instr_ff;
   logic [DATA_W-1:0] opa_ff;
   logic [DATA_W-1:0] data_ff;
   logic [1:0]        status_ff;
   logic [PC_W-1:0]   pc_ff;
   logic              run_ff;
   logic [MEM_AW-1:0] clr_ff;

   logic signed [DATA_W-1:0] rsp_data_ff;
   logic [PC_W-1:0]          rsp_pc_ff;
   logic                     rsp_halted_ff;
   logic [1:0]               rsp_status_ff;

   logic                  mem_we, mem_re;
   logic [MEM_AW-1:0]     mem_waddr, mem_raddr;
   logic [DATA_W-1:0]     mem_wdata, mem_q;
   logic                  reg_we, reg_re;
   logic [REG_AW-1:0]     reg_waddr, reg_raddr;
   logic [DATA_W-1:0]     reg_wdata, reg_q;

   logic [7:0]            op, rx, ry, rz;
   logic                  known, is_alu, is_halt, bad;
   logic                  short_op;
   logic [DATA_W-1:0]     alu_res;

   assign op = instr_ff[31:24];
   assign rx = instr_ff[23:16];
   assign ry = instr_ff[15:8];
   assign rz = instr_ff[7:0];

   always_comb begin
      known   = 1'b0;
      is_alu  = 1'b0;
      is_halt = 1'b0;
      bad     = 1'b0;
      case (op) inside
         OP_LOAD, OP_STORE, OP_MOV, OP_JNZ, OP_DEC: begin
            known = 1'b1;
            bad   = !reg_ok(rx);
         end
         OP_ADD, OP_SUB, OP_MUL: begin
            known  = 1'b1;
            is_alu = 1'b1;
            bad    = !(reg_ok(rx) && reg_ok(ry) && reg_ok(rz));
         end
         OP_HALT: begin
            known   = 1'b1;
            is_halt = 1'b1;
         end
         default: ;
      endcase
   end

   assign short_op = !known || is_halt || bad || (op == OP_MOV);

   always_comb begin
      case (op)
         OP_ADD:  alu_res = opa_ff + reg_q;
         OP_SUB:  alu_res = opa_ff - reg_q;
         default: alu_res = opa_ff * reg_q;
      endcase
   end

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = '0;
      mem_wdata = '0;
      mem_re    = 1'b0;
      mem_raddr = '0;
      if (cmd.clear) begin
         mem_we    = 1'b1;
         mem_waddr = clr_ff;
      end
      if (cmd.issue) begin
         case (action_ff)
            ACT_MEM_WR: begin
               mem_we    = 1'b1;
               mem_waddr = mem_index(addr_ff);
               mem_wdata = wdata_ff;
            end
            ACT_MEM_RD: begin
               mem_re    = 1'b1;
               mem_raddr = mem_index(addr_ff);
            end
            ACT_STEP: begin
               mem_re    = run_ff;
               mem_raddr = mem_index(pc_ff);
            end
            default: ;
         endcase
      end
      if (cmd.decode && !short_op && op == OP_LOAD) begin
         mem_re    = 1'b1;
         mem_raddr = mem_index(rz);
      end
      if (cmd.oper && op == OP_STORE) begin
         mem_we    = 1'b1;
         mem_waddr = mem_index(rz);
         mem_wdata = reg_q;
      end
   end

   always_comb begin
      reg_we    = 1'b0;
      reg_waddr = reg_idx(rx);
      reg_wdata = '0;
      reg_re    = 1'b0;
      reg_raddr = '0;
      if (cmd.clear) begin
         reg_we    = (int'(clr_ff) < REG_COUNT);
         reg_waddr = clr_ff[REG_AW-1:0];
      end
      if (cmd.issue && action_ff == ACT_REG_RD && reg_ok(addr_ff)) begin
         reg_re    = 1'b1;
         reg_raddr = reg_idx(addr_ff);
      end
      if (cmd.decode && !short_op) begin
         reg_re    = 1'b1;
         reg_raddr = is_alu ? reg_idx(ry) : reg_idx(rx);
      end
      if (cmd.decode && !bad && op == OP_MOV) begin
         reg_we    = 1'b1;
         reg_wdata = {{(DATA_W-8){1'b0}}, rz};
      end
      if (cmd.oper && is_alu) begin
         reg_re    = 1'b1;
         reg_raddr = reg_idx(rz);
      end
      if (cmd.oper && op == OP_LOAD) begin
         reg_we    = 1'b1;
         reg_wdata = mem_q;
      end
      if (cmd.oper && op == OP_DEC) begin
         reg_we    = 1'b1;
         reg_wdata = reg_q - DATA_W'(1);
      end
      if (cmd.oper2) begin
         reg_we    = 1'b1;
         reg_wdata = alu_res;
      end
   end

   trc_ram #(.WIDTH(DATA_W), .DEPTH(MEM_WORDS)) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_q)
   );

   trc_ram #(.WIDTH(DATA_W), .DEPTH(REG_COUNT)) u_regs (
      .clock   (clock),
      .wr_en   (reg_we),
      .wr_addr (reg_waddr),
      .wr_data (reg_wdata),
      .rd_en   (reg_re),
      .rd_addr (reg_raddr),
      .rd_data (reg_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear) begin
         clr_ff <= clr_ff + MEM_AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff  <= '0;
         run_ff <= 1'b1;
      end else begin
         if (cmd.decode) begin
            pc_ff <= pc_ff + PC_W'(1);
            if (is_halt) run_ff <= 1'b0;
         end
         // taken branch overrides the advance made at decode
         if (cmd.oper && op == OP_JNZ && reg_q != '0) pc_ff <= rz;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         action_ff <= req_action;
         addr_ff   <= req_address;
         wdata_ff  <= req_write_data;
      end
      if (cmd.issue) begin
         data_ff   <= '0;
         status_ff <= ST_OK;
         if (action_ff == ACT_REG_RD && !reg_ok(addr_ff)) status_ff <= ST_BADREG;
         if (action_ff == ACT_STEP && !run_ff) status_ff <= ST_HALTED;
      end
      if (cmd.take_read) begin
         data_ff <= (action_ff == ACT_MEM_RD) ? mem_q : reg_q;
      end
      if (cmd.take_instr) instr_ff <= mem_q;
      if (cmd.decode) begin
         if (!known)   status_ff <= ST_UNKNOWN;
         else if (bad) status_ff <= ST_BADREG;
         else          status_ff <= ST_OK;
         if (!bad && op == OP_MOV) data_ff <= {{(DATA_W-8){1'b0}}, rz};
      end
      if (cmd.oper) begin
         case (op)
            OP_LOAD:  data_ff <= mem_q;
            OP_STORE: data_ff <= reg_q;
            OP_DEC:   data_ff <= reg_q - DATA_W'(1);
            default:  ;
         endcase
         opa_ff <= reg_q;
      end
      if (cmd.oper2) data_ff <= alu_res;
      if (cmd.load_rsp) begin
         rsp_data_ff   <= data_ff;
         rsp_pc_ff     <= pc_ff;
         rsp_halted_ff <= ~run_ff;
         rsp_status_ff <= status_ff;
      end
   end

   assign sts.clear_last = (clr_ff == MEM_AW'(MEM_WORDS - 1));
   assign sts.action     = action_ff;
   assign sts.halted     = ~run_ff;
   assign sts.addr_bad   = ~reg_ok(addr_ff);
   assign sts.short_op   = short_op;
   assign sts.alu_op     = is_alu;

   assign rsp_read_data       = rsp_data_ff;
   assign rsp_program_counter = rsp_pc_ff;
   assign rsp_halted          = rsp_halted_ff;
   assign rsp_status          = rsp_status_ff;

endmodule

`default_nettype wire
